>>> sv/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Checks that one condition implies another at the same edge.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

>>> sv/sts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// String table package
// Field widths, request codes and status codes of the string table.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int ACTION_W  = 3;
  localparam int SYMBOL_W  = 8;
  localparam int ENTRIES_W = 7;
  localparam int STATUS_W  = 2;

  // Request actions.
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_SORT  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_QLIN  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_QBIN  = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_LONG = 2'd2;

endpackage

>>> sv/sts_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// String table channels
// Request channel (action, symbol, last) and result channel (found, entries,
// status), both with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface sts_in_if import sts_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [SYMBOL_W-1:0] symbol;
  logic                last;

  modport source (output valid, action, symbol, last, input ready);
  modport sink   (input valid, action, symbol, last, output ready);
endinterface

interface sts_out_if import sts_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 found;
  logic [ENTRIES_W-1:0] entries;
  logic [STATUS_W-1:0]  status;

  modport source (output valid, found, entries, status, input ready);
  modport sink   (input valid, found, entries, status, output ready);
endinterface

>>> sv/sts_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> sv/string_table_sort_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// String table with sort and search
// Holds up to MAX_ENTRIES byte strings and answers membership queries.
// ----------------------------------------------------------------------------
// Usage: requests enter on req_i (action, symbol, last); results leave on
// rsp_o (found, entries, status). A result to a clear, load or query byte,
// where one is due and no sort or search starts, is registered and shows on
// rsp_o the cycle after the request; sort and query results show when the walk ends.
// A sort runs an insertion sort over the table order; each string compare
// reads the lengths (ST_C_LA, ST_C_LB, ST_C_LDONE) and then each byte pair
// (ST_C_CA, ST_C_CB, ST_C_CC) from RAMs with one read port, and a sort makes
// up to N*(N-1)/2 compares in the worst case.
// A linear query takes up to N compares, a binary query about log2(N)
// compares, each after the last query byte. No request is taken while a sort
// or search runs, nor while an unread result waits and rsp_o is stalled.
// Reset empties the table and the partial fragment and query; string memory
// holds no reset and needs no clearing pass.
// ----------------------------------------------------------------------------
module string_table_sort_search import sts_pkg::*; #(
  parameter int MAX_ENTRIES = 64,
  parameter int MAX_LEN     = 128
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  sts_in_if.sink   req_i,
  sts_out_if.source rsp_o
);

`include "assert_macros.svh"

  localparam int EW  = $clog2(MAX_ENTRIES);
  localparam int CW  = $clog2(MAX_ENTRIES + 1);
  localparam int LW  = $clog2(MAX_LEN + 1);
  localparam int KW  = $clog2(MAX_LEN);
  localparam int CD  = MAX_ENTRIES * MAX_LEN;
  localparam int AAW = $clog2(CD);

  typedef enum logic [4:0] {
    ST_IDLE, ST_S_OUTER, ST_S_KEY, ST_S_INNER, ST_S_PREV, ST_S_PLACE,
    ST_L_NEXT, ST_L_GOT, ST_B_NEXT, ST_B_GOT,
    ST_C_LA, ST_C_LB, ST_C_LDONE, ST_C_CA, ST_C_CB, ST_C_CC, ST_C_RET
  } state_e;

  typedef enum logic [1:0] {OP_SORT, OP_LIN, OP_BIN} op_e;

  state_e state_q;
  op_e    op_q;

  logic [CW-1:0]   count_q, i_q, j_q;
  logic [LW-1:0]   ldpos_q, qlen_q, la_q, lb_q, k_q;
  logic [EW-1:0]   a_slot_q, b_slot_q, mid_q;
  logic signed [CW:0] l_q, r_q;
  logic [SYMBOL_W-1:0] a_chr_q;
  logic            cmp_eq_q, cmp_gt_q;

  logic                 ovalid_q, found_q;
  logic [ENTRIES_W-1:0] entries_q;
  logic [STATUS_W-1:0]  status_q;

  // Memory ports.
  logic                chr_we, len_we, ord_we, q_we;
  logic [AAW-1:0]      chr_waddr, chr_raddr;
  logic [SYMBOL_W-1:0] chr_rd, q_rd;
  logic [EW-1:0]       len_waddr, len_raddr, ord_waddr, ord_raddr, ord_wdata, ord_rd;
  logic [LW-1:0]       len_wdata, len_rd;
  logic [KW-1:0]       q_waddr, q_raddr;

  // Request decode.
  logic accept, full, ld_over, ld_store, q_over;
  logic [LW-1:0] ldpos_nx, min_len;
  logic [SYMBOL_W-1:0] b_chr;
  logic signed [CW:0] mid_w;
  logic [EW-1:0] chr_slot;

  assign req_i.ready = (state_q == ST_IDLE) && (!ovalid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;
  assign full        = (count_q == CW'(MAX_ENTRIES));
  assign ld_over     = (ldpos_q == LW'(MAX_LEN));
  assign ld_store    = !full && !ld_over;
  assign ldpos_nx    = ldpos_q + LW'(ld_store);
  assign q_over      = (qlen_q == LW'(MAX_LEN));
  assign min_len     = (la_q < lb_q) ? la_q : lb_q;
  assign b_chr       = (op_q == OP_SORT) ? chr_rd : q_rd;
  assign mid_w       = l_q + ((r_q - l_q) >>> 1);

  assign rsp_o.valid   = ovalid_q;
  assign rsp_o.found   = found_q;
  assign rsp_o.entries = entries_q;
  assign rsp_o.status  = status_q;

  // Memory addressing per state.
  always_comb begin
    chr_we    = 1'b0;
    len_we    = 1'b0;
    ord_we    = 1'b0;
    q_we      = 1'b0;
    chr_slot  = a_slot_q;
    chr_waddr = AAW'(count_q[EW-1:0]) * AAW'(MAX_LEN) + AAW'(ldpos_q);
    len_waddr = count_q[EW-1:0];
    len_wdata = ldpos_nx;
    ord_waddr = count_q[EW-1:0];
    ord_wdata = count_q[EW-1:0];
    q_waddr   = qlen_q[KW-1:0];
    q_raddr   = k_q[KW-1:0];
    len_raddr = a_slot_q;
    ord_raddr = i_q[EW-1:0];
    unique case (state_q)
      ST_IDLE: begin
        if (accept && req_i.action == ACT_LOAD) begin
          chr_we = ld_store;
          len_we = !full && req_i.last;
          ord_we = !full && req_i.last;
        end
        if (accept && (req_i.action == ACT_QLIN || req_i.action == ACT_QBIN)) begin
          q_we = !q_over;
        end
      end
      ST_S_INNER: ord_raddr = EW'(j_q - CW'(1));
      ST_B_NEXT:  ord_raddr = mid_w[EW-1:0];
      ST_C_LB:    len_raddr = b_slot_q;
      ST_C_CB:    chr_slot  = b_slot_q;
      ST_C_RET: begin
        ord_waddr = j_q[EW-1:0];
        ord_wdata = a_slot_q;
        ord_we    = (op_q == OP_SORT) && cmp_gt_q;
      end
      ST_S_PLACE: begin
        ord_waddr = j_q[EW-1:0];
        ord_wdata = b_slot_q;
        ord_we    = 1'b1;
      end
      default: ;
    endcase
    chr_raddr = AAW'(chr_slot) * AAW'(MAX_LEN) + AAW'(k_q);
  end

  sts_ram #(.WIDTH(SYMBOL_W), .DEPTH(CD)) u_chr_ram (
    .clk_i, .we_i(chr_we), .waddr_i(chr_waddr), .wdata_i(req_i.symbol),
    .raddr_i(chr_raddr), .rdata_o(chr_rd)
  );

  sts_ram #(.WIDTH(LW), .DEPTH(MAX_ENTRIES)) u_len_ram (
    .clk_i, .we_i(len_we), .waddr_i(len_waddr), .wdata_i(len_wdata),
    .raddr_i(len_raddr), .rdata_o(len_rd)
  );

  sts_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_ord_ram (
    .clk_i, .we_i(ord_we), .waddr_i(ord_waddr), .wdata_i(ord_wdata),
    .raddr_i(ord_raddr), .rdata_o(ord_rd)
  );

  sts_ram #(.WIDTH(SYMBOL_W), .DEPTH(MAX_LEN)) u_q_ram (
    .clk_i, .we_i(q_we), .waddr_i(q_waddr), .wdata_i(req_i.symbol),
    .raddr_i(q_raddr), .rdata_o(q_rd)
  );

  // Sequencer, table counters and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      op_q      <= OP_SORT;
      count_q   <= '0;
      ldpos_q   <= '0;
      qlen_q    <= '0;
      i_q       <= '0;
      j_q       <= '0;
      k_q       <= '0;
      la_q      <= '0;
      lb_q      <= '0;
      a_slot_q  <= '0;
      b_slot_q  <= '0;
      mid_q     <= '0;
      l_q       <= '0;
      r_q       <= '0;
      a_chr_q   <= '0;
      cmp_eq_q  <= 1'b0;
      cmp_gt_q  <= 1'b0;
      ovalid_q  <= 1'b0;
      found_q   <= 1'b0;
      entries_q <= '0;
      status_q  <= STAT_OK;
    end else begin
      if (ovalid_q && rsp_o.ready) begin
        ovalid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            found_q   <= 1'b0;
            status_q  <= STAT_OK;
            entries_q <= ENTRIES_W'(count_q);
            priority case (req_i.action)
              ACT_CLEAR: begin
                count_q   <= '0;
                ldpos_q   <= '0;
                qlen_q    <= '0;
                entries_q <= '0;
                ovalid_q  <= 1'b1;
              end
              ACT_LOAD: begin
                if (full) begin
                  status_q <= STAT_FULL;
                  ovalid_q <= 1'b1;
                  if (req_i.last) ldpos_q <= '0;
                end else begin
                  if (ld_over) status_q <= STAT_LONG;
                  if (req_i.last) begin
                    count_q   <= count_q + CW'(1);
                    entries_q <= ENTRIES_W'(count_q + CW'(1));
                    ldpos_q   <= '0;
                    ovalid_q  <= 1'b1;
                  end else begin
                    ldpos_q  <= ldpos_nx;
                    ovalid_q <= ld_over;
                  end
                end
              end
              ACT_SORT: begin
                op_q    <= OP_SORT;
                i_q     <= CW'(1);
                state_q <= ST_S_OUTER;
              end
              ACT_QLIN, ACT_QBIN: begin
                if (q_over) begin
                  status_q <= STAT_LONG;
                  ovalid_q <= 1'b1;
                  if (req_i.last) qlen_q <= '0;
                end else begin
                  qlen_q <= qlen_q + LW'(1);
                  if (req_i.last) begin
                    i_q <= '0;
                    l_q <= '0;
                    r_q <= $signed({1'b0, count_q}) - (CW+1)'(1);
                    if (req_i.action == ACT_QLIN) begin
                      op_q    <= OP_LIN;
                      state_q <= ST_L_NEXT;
                    end else begin
                      op_q    <= OP_BIN;
                      state_q <= ST_B_NEXT;
                    end
                  end
                end
              end
              default: ;
            endcase
          end
        end
        // Insertion sort over the table order.
        ST_S_OUTER: begin
          if (i_q >= count_q) begin
            ovalid_q <= 1'b1;
            state_q  <= ST_IDLE;
          end else begin
            state_q <= ST_S_KEY;
          end
        end
        ST_S_KEY: begin
          b_slot_q <= ord_rd;
          j_q      <= i_q;
          state_q  <= ST_S_INNER;
        end
        ST_S_INNER: begin
          state_q <= (j_q == '0) ? ST_S_PLACE : ST_S_PREV;
        end
        ST_S_PREV: begin
          a_slot_q <= ord_rd;
          state_q  <= ST_C_LA;
        end
        ST_S_PLACE: begin
          i_q     <= i_q + CW'(1);
          state_q <= ST_S_OUTER;
        end
        // Linear scan.
        ST_L_NEXT: begin
          if (i_q >= count_q) begin
            qlen_q   <= '0;
            ovalid_q <= 1'b1;
            state_q  <= ST_IDLE;
          end else begin
            state_q <= ST_L_GOT;
          end
        end
        ST_L_GOT: begin
          a_slot_q <= ord_rd;
          state_q  <= ST_C_LA;
        end
        // Binary search.
        ST_B_NEXT: begin
          if (r_q < l_q) begin
            qlen_q   <= '0;
            ovalid_q <= 1'b1;
            state_q  <= ST_IDLE;
          end else begin
            mid_q   <= mid_w[EW-1:0];
            state_q <= ST_B_GOT;
          end
        end
        ST_B_GOT: begin
          a_slot_q <= ord_rd;
          state_q  <= ST_C_LA;
        end
        // String compare: lengths first, then byte by byte.
        ST_C_LA: state_q <= ST_C_LB;
        ST_C_LB: begin
          la_q    <= len_rd;
          state_q <= ST_C_LDONE;
        end
        ST_C_LDONE: begin
          lb_q    <= (op_q == OP_SORT) ? len_rd : qlen_q;
          k_q     <= '0;
          state_q <= ST_C_CA;
        end
        ST_C_CA: begin
          if (k_q == min_len) begin
            cmp_eq_q <= (la_q == lb_q);
            cmp_gt_q <= (la_q > lb_q);
            state_q  <= ST_C_RET;
          end else begin
            state_q <= ST_C_CB;
          end
        end
        ST_C_CB: begin
          a_chr_q <= chr_rd;
          state_q <= ST_C_CC;
        end
        ST_C_CC: begin
          if (a_chr_q != b_chr) begin
            cmp_eq_q <= 1'b0;
            cmp_gt_q <= (a_chr_q > b_chr);
            state_q  <= ST_C_RET;
          end else begin
            k_q     <= k_q + LW'(1);
            state_q <= ST_C_CA;
          end
        end
        ST_C_RET: begin
          unique case (op_q)
            OP_SORT: begin
              if (cmp_gt_q) begin
                j_q     <= j_q - CW'(1);
                state_q <= ST_S_INNER;
              end else begin
                state_q <= ST_S_PLACE;
              end
            end
            OP_LIN: begin
              if (cmp_eq_q) begin
                found_q  <= 1'b1;
                qlen_q   <= '0;
                ovalid_q <= 1'b1;
                state_q  <= ST_IDLE;
              end else begin
                i_q     <= i_q + CW'(1);
                state_q <= ST_L_NEXT;
              end
            end
            default: begin
              if (cmp_eq_q) begin
                found_q  <= 1'b1;
                qlen_q   <= '0;
                ovalid_q <= 1'b1;
                state_q  <= ST_IDLE;
              end else begin
                if (cmp_gt_q) r_q <= $signed({1'b0, CW'(mid_q)}) - (CW+1)'(1);
                else          l_q <= $signed({1'b0, CW'(mid_q)}) + (CW+1)'(1);
                state_q <= ST_B_NEXT;
              end
            end
          endcase
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Checks on the sequencer and the table counters.
  `ASSERT_IMPL(a_busy_no_result, clk_i, rst_ni, state_q != ST_IDLE && $past(state_q) != ST_IDLE, !ovalid_q, "result pending while a walk runs")
  `ASSERT_CLK(a_count_max, clk_i, rst_ni, count_q <= CW'(MAX_ENTRIES), "entry count beyond table size")
  `ASSERT_CLK(a_ldpos_max, clk_i, rst_ni, ldpos_q <= LW'(MAX_LEN), "load position beyond fragment size")
  `ASSERT_CLK(a_qlen_max, clk_i, rst_ni, qlen_q <= LW'(MAX_LEN), "query length beyond buffer size")

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// String table testbench
// Drives clear, load, sort and query requests into the string table with
// random idle and stall patterns. A behavioral copy of the table predicts
// each result, and every result is checked field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import sts_pkg::*;

  localparam int NUM_SLOTS = 64;
  localparam int SLOT_LEN  = 128;
  localparam int CYCLE_LIMIT = 2000000;

  // Unused action codes; the block ignores them.
  localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

  typedef struct packed {
    logic                 found;
    logic [ENTRIES_W-1:0] entries;
    logic [STATUS_W-1:0]  status;
  } answer_t;

  logic clk_i;
  logic rst_ni;

  sts_in_if  req_ch ();
  sts_out_if rsp_ch ();

  string_table_sort_search u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch.sink),
    .rsp_o  (rsp_ch.source)
  );

  // Shadow copy of the table.
  logic [7:0] frag_mem [NUM_SLOTS][SLOT_LEN];
  int         frag_len [NUM_SLOTS];
  int         rank_slot [NUM_SLOTS];
  int         n_stored;
  int         load_pos;
  logic [7:0] qry_buf [SLOT_LEN];
  int         qry_len;

  answer_t    pending_answers [$];

  int         send_idle_pct;
  int         recv_stall_pct;
  int         hold_left;
  int         n_requests;
  int         n_checked;
  int         n_queries;
  int         n_hits;
  int         n_errors;
  int         cycle_cnt;

  logic [7:0] nucleotides [4] = '{8'h41, 8'h43, 8'h47, 8'h54};

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Run time limit.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic report(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want, n_checked);
    n_errors++;
  endtask

  // Compare a stored slot with another slot or with the query buffer.
  function automatic int order_of(input int s, input bit vs_query, input int t);
    int la;
    int lb;
    int n;
    logic [7:0] a;
    logic [7:0] b;
    la = frag_len[s];
    lb = vs_query ? qry_len : frag_len[t];
    n = (la < lb) ? la : lb;
    for (int i = 0; i < n; i++) begin
      a = frag_mem[s][i];
      b = vs_query ? qry_buf[i] : frag_mem[t][i];
      if (a != b) return (a < b) ? -1 : 1;
    end
    if (la == lb) return 0;
    return (la < lb) ? -1 : 1;
  endfunction

  function automatic void reset_table();
    n_stored = 0;
    load_pos = 0;
    qry_len  = 0;
    for (int i = 0; i < NUM_SLOTS; i++) rank_slot[i] = i;
  endfunction

  // Works out the result, if any, of one accepted request.
  function automatic void predict_request(input logic [ACTION_W-1:0] act,
                                          input logic [7:0] sym, input logic lst);
    answer_t ans;
    int key;
    int j;
    int lo;
    int hi;
    int mid;
    int c;
    ans = '0;
    case (act)
      ACT_CLEAR: begin
        reset_table();
      end
      ACT_LOAD: begin
        if (n_stored >= NUM_SLOTS) begin
          ans.status = STAT_FULL;
          if (lst) load_pos = 0;
        end else begin
          if (load_pos >= SLOT_LEN) ans.status = STAT_LONG;
          else begin
            frag_mem[n_stored][load_pos] = sym;
            load_pos++;
          end
          if (lst) begin
            frag_len[n_stored] = load_pos;
            rank_slot[n_stored] = n_stored;
            n_stored++;
            load_pos = 0;
          end else if (ans.status == STAT_OK) begin
            return;
          end
        end
      end
      ACT_SORT: begin
        for (int i = 1; i < n_stored; i++) begin
          key = rank_slot[i];
          j = i;
          while (j > 0 && order_of(rank_slot[j-1], 1'b0, key) > 0) begin
            rank_slot[j] = rank_slot[j-1];
            j--;
          end
          rank_slot[j] = key;
        end
      end
      ACT_QLIN, ACT_QBIN: begin
        if (qry_len >= SLOT_LEN) begin
          ans.status = STAT_LONG;
          if (lst) qry_len = 0;
        end else begin
          qry_buf[qry_len] = sym;
          qry_len++;
          if (!lst) return;
          if (act == ACT_QLIN) begin
            for (int i = 0; i < n_stored; i++)
              if (order_of(rank_slot[i], 1'b1, 0) == 0) ans.found = 1'b1;
          end else begin
            lo = 0;
            hi = n_stored - 1;
            while (hi >= lo && !ans.found) begin
              mid = lo + (hi - lo) / 2;
              c = order_of(rank_slot[mid], 1'b1, 0);
              if (c == 0) ans.found = 1'b1;
              else if (c > 0) hi = mid - 1;
              else lo = mid + 1;
            end
          end
          qry_len = 0;
          n_queries++;
          if (ans.found) n_hits++;
        end
      end
      default: return;
    endcase
    ans.entries = n_stored[ENTRIES_W-1:0];
    pending_answers.push_back(ans);
  endfunction

  // Sends one request and waits for it to be taken.
  task automatic send_req(input logic [ACTION_W-1:0] act, input logic [7:0] sym,
                          input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid  <= 1'b1;
    req_ch.action <= act;
    req_ch.symbol <= sym;
    req_ch.last   <= lst;
    do @(negedge clk_i); while (!req_ch.ready);
    @(posedge clk_i);
    predict_request(act, sym, lst);
    if (act <= ACT_QBIN) n_requests++;
  endtask

  function automatic logic [7:0] pick_symbol(input bit wide);
    return wide ? 8'($urandom_range(255)) : nucleotides[$urandom_range(3)];
  endfunction

  task automatic load_string(input logic [7:0] str [$]);
    foreach (str[i]) send_req(ACT_LOAD, str[i], i == str.size() - 1);
  endtask

  // Earlier query bytes take either query action; the last one decides.
  task automatic query_string(input logic [7:0] str [$], input logic [ACTION_W-1:0] act);
    foreach (str[i])
      send_req((i == str.size() - 1) ? act : ($urandom_range(1) ? ACT_QLIN : ACT_QBIN),
               str[i], i == str.size() - 1);
  endtask

  function automatic void random_string(output logic [7:0] str [$], input int len,
                                        input bit wide);
    str = {};
    repeat (len) str.push_back(pick_symbol(wide));
  endfunction

  // Result checker.
  initial begin
    answer_t want;
    forever begin
      @(negedge clk_i);
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_answers.size() == 0) begin
          report("unexpected result", 1, 0);
        end else begin
          want = pending_answers.pop_front();
          if (rsp_ch.found !== want.found) report("found", rsp_ch.found, want.found);
          if (rsp_ch.entries !== want.entries)
            report("entries", rsp_ch.entries, want.entries);
          if (rsp_ch.status !== want.status) report("status", rsp_ch.status, want.status);
        end
        n_checked++;
      end
    end
  end

  // Result ready with random stalls and an optional long hold-off.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Extremes of the fields, every action, prefixes and both searches.
  task automatic test_directed();
    logic [7:0] s [$];
    send_req(ACT_CLEAR, 8'h00, 1'b0);
    s = '{8'hFF, 8'h00};          load_string(s);
    s = '{8'h00};                 load_string(s);
    s = '{8'h00, 8'h00};          load_string(s);
    s = '{8'h7F};                 load_string(s);
    s = '{8'hFF, 8'h00};          query_string(s, ACT_QBIN);
    send_req(ACT_SORT, 8'hA5, 1'b1);
    s = '{8'h00};                 query_string(s, ACT_QBIN);
    s = '{8'h00, 8'h00};          query_string(s, ACT_QLIN);
    s = '{8'hFF};                 query_string(s, ACT_QLIN);
    send_req(ACT_SPARE_LO, 8'h12, 1'b1);
    send_req(ACT_SPARE_HI, 8'h34, 1'b0);
    s = '{8'hFF, 8'h00};          query_string(s, ACT_QBIN);
    send_req(ACT_CLEAR, 8'hFF, 1'b1);
  endtask

  // Fill all slots with short strings, overflow, sort and search the full table.
  task automatic test_table_full();
    logic [7:0] s [$];
    send_req(ACT_CLEAR, 8'h00, 1'b0);
    for (int i = 0; i < NUM_SLOTS; i++) begin
      random_string(s, $urandom_range(1, 2), 1'b1);
      load_string(s);
    end
    s = '{8'h01, 8'h02, 8'h03};   load_string(s);
    send_req(ACT_SORT, 8'h00, 1'b0);
    for (int i = 0; i < 6; i++) begin
      s = {};
      for (int k = 0; k < frag_len[rank_slot[i * 10]]; k++)
        s.push_back(frag_mem[rank_slot[i * 10]][k]);
      query_string(s, (i % 2) ? ACT_QLIN : ACT_QBIN);
    end
  endtask

  // Fragments and queries past the length limit.
  task automatic test_long_strings();
    logic [7:0] s [$];
    send_req(ACT_CLEAR, 8'h00, 1'b0);
    random_string(s, SLOT_LEN + 3, 1'b1);
    load_string(s);
    random_string(s, SLOT_LEN, 1'b0);
    load_string(s);
    query_string(s, ACT_QLIN);
    random_string(s, SLOT_LEN + 2, 1'b0);
    query_string(s, ACT_QBIN);
    s = '{8'h41};                 query_string(s, ACT_QLIN);
  endtask

  // The receiver holds off while loads keep coming, so the block backs up.
  task automatic test_backpressure();
    logic [7:0] s [$];
    send_req(ACT_CLEAR, 8'h00, 1'b0);
    hold_left = 400;
    for (int i = 0; i < 10; i++) begin
      random_string(s, 1, 1'b0);
      load_string(s);
    end
    send_req(ACT_SORT, 8'h00, 1'b0);
  endtask

  // Mostly well-formed fragment, sort and query sequences, with some noise.
  task automatic test_random(input int n_items);
    logic [7:0] s [$];
    int stop_at;
    int r;
    int slot;
    bit wide;
    stop_at = n_requests + n_items;
    while (n_requests < stop_at) begin
      r = $urandom_range(99);
      wide = ($urandom_range(9) == 0);
      if (n_stored >= 12) begin
        send_req(ACT_CLEAR, pick_symbol(1'b1), 1'($urandom_range(1)));
      end else if (r < 35) begin
        random_string(s, ($urandom_range(49) == 0) ? $urandom_range(SLOT_LEN - 1, SLOT_LEN + 3)
                                                   : $urandom_range(1, 6), wide);
        load_string(s);
      end else if (r < 45) begin
        send_req(ACT_SORT, pick_symbol(1'b1), 1'($urandom_range(1)));
      end else if (r < 90) begin
        if (n_stored > 0 && $urandom_range(1)) begin
          slot = rank_slot[$urandom_range(n_stored - 1)];
          s = {};
          for (int k = 0; k < frag_len[slot]; k++) s.push_back(frag_mem[slot][k]);
          if ($urandom_range(3) == 0 && s.size() > 1) void'(s.pop_back());
          else if ($urandom_range(3) == 0) s.push_back(pick_symbol(wide));
        end else begin
          random_string(s, ($urandom_range(49) == 0) ? SLOT_LEN + 1 : $urandom_range(1, 6),
                        wide);
        end
        query_string(s, $urandom_range(1) ? ACT_QLIN : ACT_QBIN);
      end else if (r < 95) begin
        send_req(3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)), pick_symbol(1'b1),
                 1'($urandom_range(1)));
        send_req(3'($urandom_range(ACT_QBIN)), pick_symbol(1'b1), 1'($urandom_range(1)));
      end else begin
        send_req(ACT_CLEAR, pick_symbol(1'b1), 1'($urandom_range(1)));
      end
    end
  endtask

  // Main sequence.
  initial begin
    cycle_cnt = 0;
    n_requests = 0;
    n_checked = 0;
    n_queries = 0;
    n_hits = 0;
    n_errors = 0;
    hold_left = 0;
    send_idle_pct = 25;
    recv_stall_pct = 51;
    reset_table();
    req_ch.valid  = 1'b0;
    req_ch.action = ACT_CLEAR;
    req_ch.symbol = '0;
    req_ch.last   = 1'b0;
    rsp_ch.ready  = 1'b0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_table_full();
    test_long_strings();
    test_backpressure();
    test_random(395);
    send_idle_pct = 51;
    recv_stall_pct = 25;
    test_random(395);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random(395);
    req_ch.valid <= 1'b0;

    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("Covered %0d requests and %0d results: %0d queries answered, %0d hits.",
             n_requests, n_checked, n_queries, n_hits);
    $display("Table overflow, long strings, unsorted binary search and stalls exercised.");
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/sts_pkg.sv
sv/sts_if.sv
sv/sts_ram.sv
sv/string_table_sort_search.sv
sim/tb_top.sv
